// ===== hdl/htld_pkg.sv =====
// Shared constants, codes and types for the tree-load-and-decode block.
// Used by htld_node_table and huffman_tree_load_and_decode; no dependencies.
`timescale 1ns / 1ps

package htld_pkg;

	localparam int NODE_CAP    = 512;
	localparam int STACK_CAP   = 256;
	localparam int NODE_AW     = $clog2(NODE_CAP);
	localparam int NODE_CNT_W  = $clog2(NODE_CAP + 1);
	localparam int STACK_AW    = $clog2(STACK_CAP);
	localparam int STACK_CNT_W = $clog2(STACK_CAP + 1);
	localparam int BYTE_BITS   = 8;
	localparam int BIT_CNT_W   = $clog2(BYTE_BITS + 1);

	localparam logic [7:0] LEAF_TAG = 8'h31;

	// Load and decode phases.
	localparam logic [1:0] PH_TAG    = 2'd0;
	localparam logic [1:0] PH_SYM    = 2'd1;
	localparam logic [1:0] PH_DECODE = 2'd2;
	localparam logic [1:0] PH_HALT   = 2'd3;

	// Result status codes.
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_CAPACITY = 2'd1;
	localparam logic [1:0] ST_SINGLE   = 2'd2;

	typedef logic [NODE_AW-1:0] node_idx_t;

	// Write requests into the node table, one port per field array.
	typedef struct packed {
		logic      left_we;
		node_idx_t left_addr;
		node_idx_t left_data;
		logic      right_we;
		node_idx_t right_addr;
		node_idx_t right_data;
		logic      leaf_we;
		node_idx_t leaf_addr;
		logic      leaf_data;
		logic      sym_we;
		node_idx_t sym_addr;
		logic [7:0] sym_data;
	} node_wr_t;

	// One node as read back from the table.
	typedef struct packed {
		node_idx_t  left;
		node_idx_t  right;
		logic       is_leaf;
		logic [7:0] sym;
	} node_rec_t;

endpackage

// ===== hdl/huffman_tree_load_and_decode.sv =====
// Top level: loads a preorder Huffman tree from a byte stream, then decodes code bytes.
// Depends on htld_pkg and htld_node_table.
`timescale 1ns / 1ps
//
// Channel   Handshake             Payload                 Direction
// input     in_valid / in_ready   in_byte, new_file       into the block
// output    out_valid / out_ready symbol, status, last    out of the block
//
// A tree byte (tag or symbol) is taken in S_IDLE and handled in S_DISPATCH; a tag
// that pops a pending right slot off the stack also passes S_POP, since the stack
// memory read is registered. A failing byte hands over its error result in S_FAIL.
// A code byte is taken in S_IDLE, passes S_DISPATCH, then in S_WALK makes one node
// table read per code bit, shifted out MSB first, and checks the last read; S_FLUSH
// finishes it.
// Reset clears all control state; the node table and the stack are never
// cleared, because only entries written for the current tree are read.
// A full output register stalls the walk in place; input is taken only
// between items, while a finished result may still wait in the output register.

module huffman_tree_load_and_decode
	import htld_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       new_file,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] symbol,
	output logic [1:0] status,
	output logic       last
);

	// Sequencer states.
	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_DISPATCH = 3'd1;
	localparam logic [2:0] S_POP      = 3'd2;
	localparam logic [2:0] S_WALK     = 3'd3;
	localparam logic [2:0] S_FLUSH    = 3'd4;
	localparam logic [2:0] S_FAIL     = 3'd5;

	logic [2:0]             state_q, state_d;
	logic [1:0]             phase_q, phase_d;
	logic [NODE_CNT_W-1:0]  nodes_used_q, nodes_used_d;
	logic [STACK_CNT_W-1:0] stack_level_q, stack_level_d;
	logic                   left_open_q, left_open_d;
	node_idx_t              left_parent_q, left_parent_d;
	node_idx_t              node_n_q, node_n_d;
	logic [7:0]             byte_q, byte_d;
	logic [BIT_CNT_W-1:0]   bit_cnt_q, bit_cnt_d;
	logic                   at_root_q, at_root_d;
	logic                   rd_new_q, rd_new_d;
	logic                   pend_valid_q, pend_valid_d;
	logic [7:0]             pend_sym_q, pend_sym_d;
	logic [1:0]             err_q, err_d;
	node_idx_t              root_left_q, root_right_q;
	node_idx_t              stk_rd_q;

	logic       out_valid_q;
	logic [7:0] symbol_q;
	logic [1:0] status_q;
	logic       last_q;

	// Pending right slot stack.
	node_idx_t stack_mem [STACK_CAP];
	logic                stk_we, stk_re;
	logic [STACK_AW-1:0] stk_waddr, stk_raddr;
	node_idx_t           stk_wdata;

	node_wr_t  node_wr;
	logic      node_rd_en;
	node_idx_t node_rd_addr;
	node_rec_t rd_rec;

	logic       push;
	logic [7:0] push_sym;
	logic [1:0] push_st;
	logic       push_last;

	logic                   slot_free;
	logic                   tag_finish;
	node_idx_t              tf_n;
	logic [NODE_CNT_W-1:0]  nodes_m1;
	logic [STACK_CNT_W-1:0] level_m1;
	logic                   leaf_hit;
	logic                   use_root;
	node_idx_t              cur_left, cur_right;

	htld_node_table u_node_table (
		.clk     (clk),
		.wr      (node_wr),
		.rd_en   (node_rd_en),
		.rd_addr (node_rd_addr),
		.rd_rec  (rd_rec)
	);

	assign slot_free = !out_valid_q || out_ready;
	assign nodes_m1  = nodes_used_q - NODE_CNT_W'(1);
	assign level_m1  = stack_level_q - STACK_CNT_W'(1);
	assign tf_n      = (state_q == S_POP) ? node_n_q : nodes_used_q[NODE_AW-1:0];

	// A leaf just read sends the walk back to the root; the root's children are
	// cached in registers so the next step needs no extra table read.
	assign leaf_hit  = rd_new_q && rd_rec.is_leaf;
	assign use_root  = at_root_q || leaf_hit;
	assign cur_left  = use_root ? root_left_q  : rd_rec.left;
	assign cur_right = use_root ? root_right_q : rd_rec.right;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d       = state_q;
		phase_d       = phase_q;
		nodes_used_d  = nodes_used_q;
		stack_level_d = stack_level_q;
		left_open_d   = left_open_q;
		left_parent_d = left_parent_q;
		node_n_d      = node_n_q;
		byte_d        = byte_q;
		bit_cnt_d     = bit_cnt_q;
		at_root_d     = at_root_q;
		rd_new_d      = rd_new_q;
		pend_valid_d  = pend_valid_q;
		pend_sym_d    = pend_sym_q;
		err_d         = err_q;
		node_wr       = '0;
		node_rd_en    = 1'b0;
		node_rd_addr  = byte_q[BYTE_BITS-1] ? cur_right : cur_left;
		stk_we        = 1'b0;
		stk_waddr     = stack_level_q[STACK_AW-1:0];
		stk_wdata     = tf_n;
		stk_re        = 1'b0;
		stk_raddr     = level_m1[STACK_AW-1:0];
		push          = 1'b0;
		push_sym      = pend_sym_q;
		push_st       = ST_OK;
		push_last     = 1'b0;
		tag_finish    = 1'b0;

		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					byte_d  = in_byte;
					state_d = S_DISPATCH;
					if (new_file) begin
						nodes_used_d  = '0;
						stack_level_d = '0;
						left_open_d   = 1'b0;
						left_parent_d = '0;
						phase_d       = PH_TAG;
					end
				end
			end
			S_DISPATCH: begin
				unique case (phase_q)
					PH_TAG: begin
						if (nodes_used_q >= NODE_CNT_W'(NODE_CAP)) begin
							err_d   = ST_CAPACITY;
							state_d = S_FAIL;
						end else begin
							nodes_used_d = nodes_used_q + NODE_CNT_W'(1);
							node_n_d     = nodes_used_q[NODE_AW-1:0];
							if (left_open_q) begin
								node_wr.left_we   = 1'b1;
								node_wr.left_addr = left_parent_q;
								node_wr.left_data = nodes_used_q[NODE_AW-1:0];
							end
							if (!left_open_q && stack_level_q != '0) begin
								// The new node fills the right slot on top of the stack.
								stk_re        = 1'b1;
								stack_level_d = level_m1;
								state_d       = S_POP;
							end else begin
								tag_finish = 1'b1;
							end
						end
					end
					PH_SYM: begin
						node_wr.sym_we   = 1'b1;
						node_wr.sym_addr = nodes_m1[NODE_AW-1:0];
						node_wr.sym_data = byte_q;
						if (nodes_m1[NODE_AW-1:0] == '0) begin
							err_d   = ST_SINGLE;
							state_d = S_FAIL;
						end else if (stack_level_q == '0) begin
							phase_d      = PH_DECODE;
							at_root_d    = 1'b1;
							rd_new_d     = 1'b0;
							pend_valid_d = 1'b0;
							state_d      = S_IDLE;
						end else begin
							phase_d = PH_TAG;
							state_d = S_IDLE;
						end
					end
					PH_DECODE: begin
						bit_cnt_d = '0;
						state_d   = S_WALK;
					end
					default: begin
						state_d = S_IDLE;
					end
				endcase
			end
			S_POP: begin
				node_wr.right_we   = 1'b1;
				node_wr.right_addr = stk_rd_q;
				node_wr.right_data = node_n_q;
				tag_finish         = 1'b1;
			end
			S_WALK: begin
				// A second leaf with one still pending needs the output register.
				if (!(leaf_hit && pend_valid_q && !slot_free)) begin
					if (leaf_hit) begin
						if (pend_valid_q) begin
							push = 1'b1;
						end
						pend_valid_d = 1'b1;
						pend_sym_d   = rd_rec.sym;
						at_root_d    = 1'b1;
					end
					if (bit_cnt_q != BIT_CNT_W'(BYTE_BITS)) begin
						node_rd_en = 1'b1;
						byte_d     = {byte_q[BYTE_BITS-2:0], 1'b0};
						bit_cnt_d  = bit_cnt_q + BIT_CNT_W'(1);
						rd_new_d   = 1'b1;
						at_root_d  = 1'b0;
					end else begin
						rd_new_d = 1'b0;
						state_d  = S_FLUSH;
					end
				end
			end
			S_FLUSH: begin
				if (!pend_valid_q) begin
					state_d = S_IDLE;
				end else if (slot_free) begin
					push         = 1'b1;
					push_last    = 1'b1;
					pend_valid_d = 1'b0;
					state_d      = S_IDLE;
				end
			end
			S_FAIL: begin
				if (slot_free) begin
					push      = 1'b1;
					push_sym  = '0;
					push_st   = err_q;
					push_last = 1'b1;
					phase_d   = PH_HALT;
					state_d   = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		// Second half of a tag: mark the node, and push an internal node's right slot or fail on a full stack.
		if (tag_finish) begin
			state_d = S_IDLE;
			if (byte_q == LEAF_TAG) begin
				node_wr.leaf_we   = 1'b1;
				node_wr.leaf_addr = tf_n;
				node_wr.leaf_data = 1'b1;
				left_open_d       = 1'b0;
				phase_d           = PH_SYM;
			end else if (stack_level_q >= STACK_CNT_W'(STACK_CAP)) begin
				err_d   = ST_CAPACITY;
				state_d = S_FAIL;
			end else begin
				node_wr.leaf_we   = 1'b1;
				node_wr.leaf_addr = tf_n;
				node_wr.leaf_data = 1'b0;
				stk_we            = 1'b1;
				stack_level_d     = stack_level_q + STACK_CNT_W'(1);
				left_open_d       = 1'b1;
				left_parent_d     = tf_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			phase_q       <= PH_TAG;
			nodes_used_q  <= '0;
			stack_level_q <= '0;
			left_open_q   <= 1'b0;
			left_parent_q <= '0;
			bit_cnt_q     <= '0;
			at_root_q     <= 1'b1;
			rd_new_q      <= 1'b0;
			pend_valid_q  <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q       <= state_d;
			phase_q       <= phase_d;
			nodes_used_q  <= nodes_used_d;
			stack_level_q <= stack_level_d;
			left_open_q   <= left_open_d;
			left_parent_q <= left_parent_d;
			bit_cnt_q     <= bit_cnt_d;
			at_root_q     <= at_root_d;
			rd_new_q      <= rd_new_d;
			pend_valid_q  <= pend_valid_d;
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		node_n_q   <= node_n_d;
		byte_q     <= byte_d;
		pend_sym_q <= pend_sym_d;
		err_q      <= err_d;
		if (push) begin
			symbol_q <= push_sym;
			status_q <= push_st;
			last_q   <= push_last;
		end
		if (node_wr.left_we && node_wr.left_addr == '0) begin
			root_left_q <= node_wr.left_data;
		end
		if (node_wr.right_we && node_wr.right_addr == '0) begin
			root_right_q <= node_wr.right_data;
		end
	end

	// Stack memory, registered read.
	always_ff @(posedge clk) begin
		if (stk_we) begin
			stack_mem[stk_waddr] <= stk_wdata;
		end
		if (stk_re) begin
			stk_rd_q <= stack_mem[stk_raddr];
		end
	end

	assign out_valid = out_valid_q;
	assign symbol    = symbol_q;
	assign status    = status_q;
	assign last      = last_q;

endmodule

// ===== hdl/htld_node_table.sv =====
// Node table: left child, right child, leaf flag and symbol arrays.
// Each array has its own write port; all share one read address and registered read data.
// Depends on htld_pkg.
`timescale 1ns / 1ps

module htld_node_table
	import htld_pkg::*;
(
	input  logic      clk,
	input  node_wr_t  wr,
	input  logic      rd_en,
	input  node_idx_t rd_addr,
	output node_rec_t rd_rec
);

	node_idx_t  left_mem  [NODE_CAP];
	node_idx_t  right_mem [NODE_CAP];
	logic       leaf_mem  [NODE_CAP];
	logic [7:0] sym_mem   [NODE_CAP];

	node_rec_t rd_rec_q;

	always_ff @(posedge clk) begin
		if (wr.left_we) begin
			left_mem[wr.left_addr] <= wr.left_data;
		end
		if (wr.right_we) begin
			right_mem[wr.right_addr] <= wr.right_data;
		end
		if (wr.leaf_we) begin
			leaf_mem[wr.leaf_addr] <= wr.leaf_data;
		end
		if (wr.sym_we) begin
			sym_mem[wr.sym_addr] <= wr.sym_data;
		end
	end

	// The read data holds while no read is issued, so it doubles as the walk position.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_rec_q.left    <= left_mem[rd_addr];
			rd_rec_q.right   <= right_mem[rd_addr];
			rd_rec_q.is_leaf <= leaf_mem[rd_addr];
			rd_rec_q.sym     <= sym_mem[rd_addr];
		end
	end

	assign rd_rec = rd_rec_q;

endmodule

// ===== tb/htld_symbol_check.sv =====
// Watches both channels of the tree-load-and-decode block, predicts its symbols and compares them.
// Depends on htld_pkg; instantiated beside the block by huffman_tree_load_and_decode_tb.
`timescale 1ns / 1ps

module htld_symbol_check
	import htld_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       new_file,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic [7:0] symbol,
	input  logic [1:0] status,
	input  logic       last,
	output int         fail_count,
	output int         pending
);

	typedef struct packed {
		logic [7:0] sym;
		logic [1:0] st;
		logic       lst;
	} symbol_result_t;

	symbol_result_t expected_symbols[$];

	// Shadow copy of the tree and the loader state.
	node_idx_t              left_tbl [NODE_CAP];
	node_idx_t              right_tbl[NODE_CAP];
	logic                   leaf_tbl [NODE_CAP];
	logic [7:0]             sym_tbl  [NODE_CAP];
	node_idx_t              right_slots[STACK_CAP];
	logic [NODE_CNT_W-1:0]  used;
	logic [STACK_CNT_W-1:0] slot_depth;
	logic                   left_open;
	node_idx_t              left_parent;
	logic [1:0]             ph;
	node_idx_t              walk;

	function automatic void restart_tree();
		used        = '0;
		slot_depth  = '0;
		left_open   = 1'b0;
		left_parent = '0;
		ph          = PH_TAG;
		walk        = '0;
	endfunction

	function automatic void halt_with(input logic [1:0] code);
		ph = PH_HALT;
		expected_symbols.push_back('{8'h00, code, 1'b1});
	endfunction

	// Advances the shadow state by one byte and queues the symbols it yields.
	function automatic void predict_symbols(input logic [7:0] b, input logic nf);
		node_idx_t      n;
		node_idx_t      w;
		symbol_result_t held;
		logic           have_held;
		int             i;
		have_held = 1'b0;
		held      = '0;
		if (nf)
			restart_tree();
		case (ph)
			PH_TAG: begin
				if (used >= NODE_CAP) begin
					halt_with(ST_CAPACITY);
				end else begin
					n    = node_idx_t'(used);
					used = used + 1'b1;
					if (left_open) begin
						left_tbl[left_parent] = n;
					end else if (slot_depth > 0) begin
						slot_depth = slot_depth - 1'b1;
						right_tbl[right_slots[slot_depth[STACK_AW-1:0]]] = n;
					end
					if (b == LEAF_TAG) begin
						leaf_tbl[n] = 1'b1;
						left_open   = 1'b0;
						ph          = PH_SYM;
					end else if (slot_depth >= STACK_CAP) begin
						halt_with(ST_CAPACITY);
					end else begin
						leaf_tbl[n] = 1'b0;
						right_slots[slot_depth[STACK_AW-1:0]] = n;
						slot_depth  = slot_depth + 1'b1;
						left_open   = 1'b1;
						left_parent = n;
					end
				end
			end
			PH_SYM: begin
				n = node_idx_t'(used - 1'b1);
				sym_tbl[n] = b;
				if (n == 0) begin
					halt_with(ST_SINGLE);
				end else if (slot_depth == 0) begin
					ph   = PH_DECODE;
					walk = '0;
				end else begin
					ph = PH_TAG;
				end
			end
			PH_DECODE: begin
				w = walk;
				for (i = BYTE_BITS - 1; i >= 0; i--) begin
					w = b[i] ? right_tbl[w] : left_tbl[w];
					if (leaf_tbl[w]) begin
						if (have_held)
							expected_symbols.push_back(held);
						held      = '{sym_tbl[w], ST_OK, 1'b0};
						have_held = 1'b1;
						w         = '0;
					end
				end
				walk = w;
				if (have_held) begin
					held.lst = 1'b1;
					expected_symbols.push_back(held);
				end
			end
			default: ;
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		symbol_result_t exp_r;
		if (!arst_n) begin
			restart_tree();
			expected_symbols.delete();
			fail_count = 0;
			pending    = 0;
		end else begin
			// Results leave before the byte taken at this edge can have produced any.
			if (out_valid && out_ready) begin
				if (expected_symbols.size() == 0) begin
					if (fail_count < 10)
						$display("%0t: unexpected result symbol=%02h status=%0d last=%b",
							$realtime, symbol, status, last);
					fail_count++;
				end else begin
					exp_r = expected_symbols.pop_front();
					if (exp_r.sym !== symbol || exp_r.st !== status || exp_r.lst !== last) begin
						if (fail_count < 10)
							$display("%0t: mismatch expected symbol=%02h status=%0d last=%b, got symbol=%02h status=%0d last=%b",
								$realtime, exp_r.sym, exp_r.st, exp_r.lst, symbol, status, last);
						fail_count++;
					end
				end
			end
			if (in_valid && in_ready)
				predict_symbols(in_byte, new_file);
			pending = expected_symbols.size();
		end
	end

endmodule

// ===== tb/huffman_tree_load_and_decode_tb.sv =====
// Stimulus and verdict for huffman_tree_load_and_decode: trees, code bytes and capacity cases.
// Depends on htld_pkg, the block itself and htld_symbol_check.
`timescale 1ns / 1ps

module huffman_tree_load_and_decode_tb;
	import htld_pkg::*;

	// The slowest correct run stays well under a quarter of this: every byte waiting
	// out the longest sender gap, eight results each waiting out the longest stall.
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int RANDOM_ITEMS = 220;
	localparam int MAX_GAP      = 17;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic [7:0] in_byte   = 8'h00;
	logic       new_file  = 1'b0;
	logic       out_ready = 1'b0;
	logic       in_ready;
	logic       out_valid;
	logic [7:0] symbol;
	logic [1:0] status;
	logic       last;

	int   fail_count;
	int   pending;
	int   cycles     = 0;
	int   sent_items = 0;
	// While set, neither side idles, so the block runs back to back.
	logic quiet      = 1'b0;

	always #5 clk = ~clk;

	huffman_tree_load_and_decode u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_byte   (in_byte),
		.new_file  (new_file),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.symbol    (symbol),
		.status    (status),
		.last      (last)
	);

	htld_symbol_check u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_byte    (in_byte),
		.new_file   (new_file),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.symbol     (symbol),
		.status     (status),
		.last       (last),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// A run that hangs anywhere ends here.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("huffman_tree_load_and_decode regression: fail");
			$finish;
		end
	end

	// One byte transfer. The task is entered and left at a falling edge. With no gap
	// the valid simply stays high and only the payload changes, so valid is never
	// lowered and raised in the same step.
	task automatic send_byte(input logic [7:0] b, input logic nf);
		int gap;
		gap = quiet ? 0 : int'($urandom_range(0, MAX_GAP));
		if (gap != 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_byte  = b;
		new_file = nf;
		in_valid = 1'b1;
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
		sent_items++;
	endtask

	// Sends a random full tree with the given number of leaves in preorder. A tree
	// is kept well formed by never closing the last open slot while internal nodes
	// are still owed. A nonzero cut stops the description after that many bytes,
	// which leaves the loader waiting in the middle of a tree.
	task automatic send_tree(input int leaves, input logic nf, input int cut);
		int         open_slots;
		int         internals_left;
		int         sent;
		logic       can_leaf;
		logic       take_internal;
		logic [7:0] tag;
		open_slots     = 1;
		internals_left = leaves - 1;
		sent           = 0;
		while (open_slots > 0) begin
			can_leaf      = (open_slots > 1) || (internals_left == 0);
			take_internal = (internals_left > 0) && (!can_leaf || $urandom_range(0, 1));
			if (take_internal) begin
				do
					tag = 8'($urandom_range(0, 255));
				while (tag == LEAF_TAG);
				send_byte(tag, nf && sent == 0);
				internals_left--;
				open_slots++;
				sent++;
			end else begin
				send_byte(LEAF_TAG, nf && sent == 0);
				sent++;
				if (cut != 0 && sent >= cut)
					return;
				send_byte(8'($urandom_range(0, 255)), 1'b0);
				open_slots--;
				sent++;
			end
			if (cut != 0 && sent >= cut)
				return;
		end
	endtask

	// The receiver draws a stall before every result, then waits for the transfer
	// with ready held high.
	initial begin
		int stall;
		forever begin
			stall = quiet ? 0 : int'($urandom_range(0, MAX_GAP));
			if (stall != 0) begin
				out_ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready = 1'b1;
			do
				@(posedge clk);
			while (!out_valid);
			@(negedge clk);
		end
	end

	initial begin
		int kind;
		int stop_at;
		int i;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Two leaves holding the extreme symbols. The code bytes then give eight
		// results each: all left, all right, and a mix.
		send_byte(8'h00, 1'b1);
		send_byte(LEAF_TAG, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(LEAF_TAG, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hA5, 1'b0);

		// Three leaves, an internal tag next to the leaf tag, and a leaf whose symbol
		// equals the leaf tag. Codes are 0, 10 and 11, and the code bytes use all three.
		send_byte(8'hFF, 1'b1);
		send_byte(LEAF_TAG, 1'b0);
		send_byte(LEAF_TAG, 1'b0);
		send_byte(8'h30, 1'b0);
		send_byte(LEAF_TAG, 1'b0);
		send_byte(8'h42, 1'b0);
		send_byte(LEAF_TAG, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'h5B, 1'b0);
		send_byte(8'h80, 1'b0);

		// A new file in the middle of decoding whose tree is a lone leaf. The block
		// halts, and the two bytes after it must be ignored.
		send_byte(LEAF_TAG, 1'b1);
		send_byte(8'h7E, 1'b0);
		send_byte(8'h12, 1'b0);
		send_byte(8'hFF, 1'b0);

		// A tree cut short by a new file, then a complete one.
		send_byte(8'h01, 1'b1);
		send_byte(LEAF_TAG, 1'b0);
		send_byte(8'h55, 1'b0);
		send_tree(2, 1'b1, 0);
		send_byte(8'h3C, 1'b0);

		// Stack overflow: a left spine of internal nodes one deeper than the stack.
		send_byte(8'h00, 1'b1);
		repeat (STACK_CAP) send_byte(8'h00, 1'b0);
		send_byte(LEAF_TAG, 1'b0);

		// Node table overflow: internal nodes with a leaf on the left keep one right
		// slot pending, so the table fills before the tree closes. One more tag fails.
		for (i = 0; i < NODE_CAP / 2; i++) begin
			send_byte(8'h00, i == 0);
			send_byte(LEAF_TAG, 1'b0);
			send_byte(8'($urandom_range(0, 255)), 1'b0);
		end
		send_byte(LEAF_TAG, 1'b0);
		send_byte(8'h99, 1'b0);

		// Random part: mostly complete trees followed by code bytes, with cut trees,
		// lone leaves and loose bytes mixed in.
		stop_at = sent_items + RANDOM_ITEMS;
		while (sent_items < stop_at) begin
			quiet = ($urandom_range(0, 4) == 0);
			kind  = int'($urandom_range(0, 9));
			if (kind <= 6) begin
				send_tree(int'($urandom_range(2, 12)), 1'b1, 0);
				repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)), 1'b0);
			end else if (kind == 7) begin
				send_tree(int'($urandom_range(2, 12)), 1'b1, int'($urandom_range(1, 6)));
			end else if (kind == 8) begin
				repeat ($urandom_range(1, 4))
					send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
			end else begin
				send_tree(1, 1'b1, 0);
				send_byte(8'($urandom_range(0, 255)), 1'b0);
			end
		end
		quiet    = 1'b0;
		in_valid = 1'b0;

		// Drain what is still owed, then give the block time to show any extra result.
		while (pending != 0)
			@(negedge clk);
		repeat (40) @(negedge clk);

		if (fail_count == 0 && pending == 0)
			$display("huffman_tree_load_and_decode regression: pass");
		else
			$display("huffman_tree_load_and_decode regression: fail");
		$finish;
	end

endmodule

// ===== huffman_tree_load_and_decode.f =====
hdl/htld_pkg.sv
hdl/htld_node_table.sv
hdl/huffman_tree_load_and_decode.sv
tb/htld_symbol_check.sv
tb/huffman_tree_load_and_decode_tb.sv
